>>> rtl/core/time_triggered_task_release_assert.svh
// ----------------------------------------------------------------------------
// time_triggered_task_release_assert.svh
// assertion macros for the task release block, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TIME_TRIGGERED_TASK_RELEASE_ASSERT_SVH
`define TIME_TRIGGERED_TASK_RELEASE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define TTR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TTR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define TTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/ttr_pkg.sv
// ----------------------------------------------------------------------------
// ttr_pkg
// types, codes and microcode table of the task release block
// ----------------------------------------------------------------------------
package ttr_pkg;

  localparam int UPC_W = 3;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SCAN = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;

  localparam logic [UPC_W-1:0] STEP_FETCH = 3'd0;
  localparam logic [UPC_W-1:0] STEP_LOAD  = 3'd1;
  localparam logic [UPC_W-1:0] STEP_TICK  = 3'd2;
  localparam logic [UPC_W-1:0] STEP_SCAN  = 3'd3;
  localparam logic [UPC_W-1:0] STEP_FLUSH = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  task_slot;
    logic [14:0] period;
    logic [14:0] first_delay;
  } in_word_t;

  typedef struct packed {
    logic       task_valid;
    logic [2:0] task_index;
    logic       last;
  } out_word_t;

  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_FETCH,
    ACT_LOAD,
    ACT_TICK,
    ACT_SCAN,
    ACT_FLUSH
  } act_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_DECODE,
    COND_LOOP,
    COND_WAIT
  } cond_t;

  typedef struct packed {
    act_t             act;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic [UPC_W-1:0] exit_to;
  } ucode_t;

  typedef struct packed {
    act_t act;
    logic take;
  } ctrl_t;

  typedef struct packed {
    logic idx_last;
    logic stall;
  } status_t;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t cw;
    case (upc)
      STEP_FETCH: cw = '{ACT_FETCH, COND_DECODE, STEP_FETCH, STEP_FETCH};
      STEP_LOAD:  cw = '{ACT_LOAD,  COND_ALWAYS, STEP_FETCH, STEP_FETCH};
      STEP_TICK:  cw = '{ACT_TICK,  COND_LOOP,   STEP_TICK,  STEP_FETCH};
      STEP_SCAN:  cw = '{ACT_SCAN,  COND_LOOP,   STEP_SCAN,  STEP_FLUSH};
      STEP_FLUSH: cw = '{ACT_FLUSH, COND_WAIT,   STEP_FETCH, STEP_FETCH};
      default:    cw = '{ACT_NOP,   COND_ALWAYS, STEP_FETCH, STEP_FETCH};
    endcase
    return cw;
  endfunction

  function automatic logic [UPC_W-1:0] cmd_entry(input logic [1:0] cmd);
    logic [UPC_W-1:0] s;
    case (cmd)
      CMD_TICK: s = STEP_TICK;
      CMD_SCAN: s = STEP_SCAN;
      CMD_LOAD: s = STEP_LOAD;
      default:  s = STEP_FETCH;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/ttr_sequencer.sv
// ----------------------------------------------------------------------------
// ttr_sequencer
// step counter over the microcode table with conditional jumps
// ----------------------------------------------------------------------------
module ttr_sequencer import ttr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  input  status_t    status,
  output ctrl_t      ctrl
);

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  ucode_t           cw;

  assign cw = ucode_rom(upc_r);

  always_comb begin
    upc_nxt = upc_r;
    case (cw.cond)
      COND_ALWAYS: upc_nxt = cw.target;
      COND_DECODE: begin
        if (in_valid) upc_nxt = cmd_entry(in_cmd);
      end
      COND_LOOP: begin
        if (!status.stall) upc_nxt = status.idx_last ? cw.exit_to : cw.target;
      end
      COND_WAIT: begin
        if (!status.stall) upc_nxt = cw.target;
      end
      default: upc_nxt = STEP_FETCH;
    endcase
  end

  always_comb begin
    ctrl.act  = cw.act;
    ctrl.take = (cw.act == ACT_FETCH) && in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

>>> rtl/core/ttr_datapath.sv
// ----------------------------------------------------------------------------
// ttr_datapath
// slot file, scan index, pending release and output word register
// ----------------------------------------------------------------------------
module ttr_datapath import ttr_pkg::*; #(
  parameter int NUM_TASKS  = 8,
  parameter int TIMER_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_t     ctrl,
  input  in_word_t  in_word,
  output status_t   status,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TASKS - 1);
  localparam logic [31:0] TMR_MAX_U = (32'd1 << (TIMER_BITS - 1)) - 32'd1;
  localparam logic [TIMER_BITS-1:0] TMR_MIN = {1'b1, {(TIMER_BITS-1){1'b0}}};
  localparam logic [TIMER_BITS-1:0] TMR_ONE = TIMER_BITS'(1);

  logic                  slot_active_r [NUM_TASKS];
  logic [TIMER_BITS-1:0] slot_timer_r  [NUM_TASKS];
  logic [14:0]           slot_period_r [NUM_TASKS];

  in_word_t   word_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;

  logic                  cur_active;
  logic [TIMER_BITS-1:0] cur_timer;
  logic [14:0]           cur_period;
  logic                  idx_last;
  logic                  release_hit;
  logic                  out_free;
  logic                  stall;
  logic                  load_ok;
  logic [31:0]           slot_ext;
  logic [31:0]           pend_ext;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic                  act_we, act_wd;
  logic                  tmr_we;
  logic [TIMER_BITS-1:0] tmr_wd;
  logic                  per_we;

  function automatic logic [TIMER_BITS-1:0] clamp_timer(input logic [14:0] v);
    logic [31:0] v_ext;
    v_ext = {17'd0, v};
    if (v_ext > TMR_MAX_U) return TMR_MAX_U[TIMER_BITS-1:0];
    return v_ext[TIMER_BITS-1:0];
  endfunction

  assign cur_active  = slot_active_r[idx_r];
  assign cur_timer   = slot_timer_r[idx_r];
  assign cur_period  = slot_period_r[idx_r];
  assign idx_last    = (idx_r == IDX_LAST);
  assign release_hit = cur_active && (cur_timer[TIMER_BITS-1] || (cur_timer == '0));
  assign out_free    = !out_valid_r || out_ready;
  assign slot_ext    = {29'd0, word_r.task_slot};
  assign load_ok     = slot_ext < 32'(NUM_TASKS);
  assign pend_ext    = 32'(pend_idx_r);

  always_comb begin
    case (ctrl.act)
      ACT_SCAN:  stall = release_hit && pend_valid_r && !out_free;
      ACT_FLUSH: stall = !out_free;
      default:   stall = 1'b0;
    endcase
  end

  always_comb begin
    status.idx_last = idx_last;
    status.stall    = stall;
  end

  always_comb begin
    idx_nxt        = idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_word_nxt   = out_word_r;
    wr_en          = 1'b0;
    wr_idx         = idx_r;
    act_we         = 1'b0;
    act_wd         = 1'b0;
    tmr_we         = 1'b0;
    tmr_wd         = cur_timer;
    per_we         = 1'b0;
    case (ctrl.act)
      ACT_FETCH: begin
        idx_nxt        = '0;
        pend_valid_nxt = 1'b0;
      end
      ACT_LOAD: begin
        wr_en  = load_ok;
        wr_idx = slot_ext[IDX_W-1:0];
        act_we = 1'b1;
        act_wd = 1'b1;
        tmr_we = 1'b1;
        tmr_wd = clamp_timer(word_r.first_delay);
        per_we = 1'b1;
      end
      ACT_TICK: begin
        wr_en   = cur_active && (cur_timer != TMR_MIN);
        tmr_we  = 1'b1;
        tmr_wd  = cur_timer - TMR_ONE;
        idx_nxt = idx_last ? idx_r : idx_r + 1'b1;
      end
      ACT_SCAN: begin
        if (!stall) begin
          if (release_hit) begin
            wr_en  = 1'b1;
            tmr_we = 1'b1;
            if (cur_period == '0) begin
              act_we = 1'b1;
              act_wd = 1'b0;
              tmr_wd = TMR_ONE;
            end else begin
              tmr_wd = clamp_timer(cur_period);
            end
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{1'b1, pend_ext[2:0], 1'b0};
            end
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = idx_r;
          end
          idx_nxt = idx_last ? idx_r : idx_r + 1'b1;
        end
      end
      ACT_FLUSH: begin
        if (!stall) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = '{pend_valid_r, pend_valid_r ? pend_ext[2:0] : 3'd0, 1'b1};
          pend_valid_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) word_r <= in_word;
    idx_r        <= idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    out_word_r   <= out_word_nxt;
    if (wr_en && per_we) slot_period_r[wr_idx] <= word_r.period;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        slot_active_r[i] <= 1'b0;
        slot_timer_r[i]  <= TMR_ONE;
      end
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (wr_en && act_we) slot_active_r[wr_idx] <= act_wd;
      if (wr_en && tmr_we) slot_timer_r[wr_idx]  <= tmr_wd;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/core/time_triggered_task_release.sv
// ----------------------------------------------------------------------------
// time_triggered_task_release
// time-triggered task slot table with tick, load and dispatch scan
// ----------------------------------------------------------------------------
// usage
//   in_word carries one command (tick, dispatch scan or slot load) under
//   in_valid/in_ready; out_word carries released slot indices under
//   out_valid/out_ready, one word per release, last set on the final one.
//   a scan with no release returns one word with task_valid low, last high.
// timing
//   the microcode program handles one command at a time, one slot a cycle
//   while the scan step is not stalled; tick and scan loop over the slot
//   file, and no new command is taken until the program is back at fetch.
// reset
//   synchronous active-low reset clears all active marks, sets every timer
//   to one and empties the output register; periods are not cleared.
// stalls
//   a stalled receiver holds the output word; the scan step waits when a
//   new release or the final word needs the output register, and no
//   command is taken.
// ----------------------------------------------------------------------------
module time_triggered_task_release import ttr_pkg::*; #(
  parameter int NUM_TASKS  = 8,
  parameter int TIMER_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  ctrl_t   ctrl;
  status_t status;

  ttr_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_word.command),
    .status   (status),
    .ctrl     (ctrl)
  );

  ttr_datapath #(
    .NUM_TASKS  (NUM_TASKS),
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_word   (in_word),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign in_ready = (ctrl.act == ACT_FETCH);

`include "time_triggered_task_release_assert.svh"

  `TTR_ASSERT_NEXT(a_scan_blocks_input, clk, rst_n, in_valid && in_ready && (in_word.command == CMD_SCAN), !in_ready, "input taken during scan")
  `TTR_ASSERT_NOW(a_stall_only_on_output, clk, rst_n, status.stall, (ctrl.act == ACT_SCAN) || (ctrl.act == ACT_FLUSH), "stall outside scan")
  `TTR_ASSERT_NEXT(a_flush_gives_last, clk, rst_n, (ctrl.act == ACT_FLUSH) && !status.stall, out_valid && out_word.last, "scan end without last word")

endmodule

>>> tb/time_triggered_task_release_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_triggered_task_release_tb
// self-checking bench for the task release block: a queued driver sends
// tick, scan, load and unused-code words, a scoreboard of release words is
// kept by a local slot-table predictor, and the monitor checks every output
// word, with random stalls on both channels outside the no-idle phases
module time_triggered_task_release_tb;
  import ttr_pkg::*;

  localparam int              NUM_SLOTS  = 8;
  localparam logic [1:0]      CMD_UNUSED = 2'd3;
  localparam logic signed [15:0] TMR_MIN = 16'sh8000;
  localparam int              STALL_PCT  = 22;
  localparam int              DOG_LIMIT  = 2000;
  localparam int              TAIL_WAIT  = 30;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  in_word_t  cmd_q[$];
  out_word_t release_q[$];

  logic                slot_on[NUM_SLOTS];
  logic signed [15:0]  slot_cnt[NUM_SLOTS];
  logic [14:0]         slot_reload[NUM_SLOTS];

  logic no_idle = 1'b0;
  int   fails = 0;
  int   n_ticks = 0;
  int   n_scans = 0;
  int   n_loads = 0;
  int   n_ignored = 0;
  int   n_words = 0;
  int   quiet_cycles = 0;

  time_triggered_task_release u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic predict_releases(input in_word_t w);
    out_word_t hits[NUM_SLOTS];
    out_word_t wd;
    int        n;
    n = 0;
    case (w.command)
      CMD_TICK: begin
        n_ticks++;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_on[i] && slot_cnt[i] != TMR_MIN) slot_cnt[i] = slot_cnt[i] - 16'sd1;
        end
      end
      CMD_LOAD: begin
        n_loads++;
        slot_on[w.task_slot]     = 1'b1;
        slot_reload[w.task_slot] = w.period;
        slot_cnt[w.task_slot]    = {1'b0, w.first_delay};
      end
      CMD_SCAN: begin
        n_scans++;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_on[i] && slot_cnt[i] <= 16'sd0) begin
            if (slot_reload[i] == '0) begin
              slot_on[i]  = 1'b0;
              slot_cnt[i] = 16'sd1;
            end else begin
              slot_cnt[i] = {1'b0, slot_reload[i]};
            end
            hits[n] = '{task_valid: 1'b1, task_index: 3'(i), last: 1'b0};
            n++;
          end
        end
        if (n == 0) begin
          wd = '{task_valid: 1'b0, task_index: 3'd0, last: 1'b1};
          release_q.push_back(wd);
        end else begin
          for (int k = 0; k < n; k++) begin
            wd = hits[k];
            wd.last = (k == n - 1);
            release_q.push_back(wd);
          end
        end
      end
      default: n_ignored++;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_releases(in_word);
      if (!in_valid || in_ready) begin
        if (cmd_q.size() > 0 && (no_idle || $urandom_range(99) >= STALL_PCT)) begin
          in_valid <= 1'b1;
          in_word  <= cmd_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    out_word_t exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_words++;
        if (release_q.size() == 0) begin
          $error("unexpected release word %p", out_word);
          fails++;
        end else begin
          exp_w = release_q.pop_front();
          if (out_word.task_valid !== exp_w.task_valid) begin
            $error("task_valid: expected %0d, got %0d", exp_w.task_valid, out_word.task_valid);
            fails++;
          end
          if (out_word.task_index !== exp_w.task_index) begin
            $error("task_index: expected %0d, got %0d", exp_w.task_index, out_word.task_index);
            fails++;
          end
          if (out_word.last !== exp_w.last) begin
            $error("last: expected %0d, got %0d", exp_w.last, out_word.last);
            fails++;
          end
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= STALL_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= DOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", DOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_cmd(input logic [1:0] cmd, input logic [2:0] slot,
                          input logic [14:0] per, input logic [14:0] dly);
    in_word_t w;
    w = '{command: cmd, task_slot: slot, period: per, first_delay: dly};
    cmd_q.push_back(w);
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || in_valid || release_q.size() != 0) @(negedge clk);
  endtask

  task automatic push_random(input int count);
    int          made;
    int          r;
    logic [14:0] per;
    logic [14:0] dly;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      per = ($urandom_range(99) < 70) ? 15'($urandom_range(6)) : 15'($urandom_range(32767));
      dly = ($urandom_range(99) < 70) ? 15'($urandom_range(8)) : 15'($urandom_range(32767));
      if (r < 40) begin
        push_cmd(CMD_TICK, 3'($urandom_range(7)), 15'($urandom), 15'($urandom));
        made++;
      end else if (r < 62) begin
        push_cmd(CMD_SCAN, 3'($urandom_range(7)), 15'($urandom), 15'($urandom));
        made++;
      end else if (r < 94) begin
        push_cmd(CMD_LOAD, 3'($urandom_range(7)), per, dly);
        made++;
      end else begin
        push_cmd(CMD_UNUSED, 3'($urandom_range(7)), 15'($urandom), 15'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_on[i]     = 1'b0;
      slot_cnt[i]    = 16'sd1;
      slot_reload[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, one-shot, periodic, extremes, ignored code
    push_cmd(CMD_SCAN, 3'd0, 15'd0, 15'd0);
    push_cmd(CMD_TICK, 3'd7, 15'h7fff, 15'h7fff);
    push_cmd(CMD_UNUSED, 3'd7, 15'h7fff, 15'h7fff);
    push_cmd(CMD_LOAD, 3'd0, 15'd0, 15'd0);
    push_cmd(CMD_LOAD, 3'd7, 15'h7fff, 15'h7fff);
    push_cmd(CMD_LOAD, 3'd3, 15'd1, 15'd1);
    push_cmd(CMD_LOAD, 3'd5, 15'd2, 15'd0);
    push_cmd(CMD_SCAN, 3'd0, 15'd0, 15'd0);
    push_cmd(CMD_TICK, 3'd0, 15'd0, 15'd0);
    push_cmd(CMD_SCAN, 3'd5, 15'h5555, 15'h2aaa);
    push_cmd(CMD_SCAN, 3'd2, 15'h2aaa, 15'h5555);
    push_cmd(CMD_LOAD, 3'd6, 15'h2aaa, 15'h5555);
    push_cmd(CMD_LOAD, 3'd1, 15'h5555, 15'h2aaa);
    push_cmd(CMD_LOAD, 3'd2, 15'd0, 15'd1);
    push_cmd(CMD_LOAD, 3'd4, 15'd3, 15'd2);
    push_cmd(CMD_TICK, 3'd0, 15'd0, 15'd0);
    push_cmd(CMD_SCAN, 3'd0, 15'd0, 15'd0);
    push_cmd(CMD_TICK, 3'd0, 15'd0, 15'd0);
    push_cmd(CMD_TICK, 3'd0, 15'd0, 15'd0);
    push_cmd(CMD_SCAN, 3'd0, 15'd0, 15'd0);
    push_cmd(CMD_SCAN, 3'd0, 15'd0, 15'd0);
    push_cmd(CMD_LOAD, 3'd4, 15'd0, 15'd0);
    push_cmd(CMD_SCAN, 3'd0, 15'd0, 15'd0);
    drain();

    // random with stalls on both sides
    push_random(110);
    drain();

    // random without any idling
    no_idle = 1'b1;
    push_random(110);
    drain();

    // periodic and one-shot slots counting below zero, back to back
    push_cmd(CMD_LOAD, 3'd4, 15'd3, 15'd0);
    push_cmd(CMD_LOAD, 3'd2, 15'd0, 15'd1);
    for (int i = 0; i < 4; i++) push_cmd(CMD_TICK, 3'd0, 15'd0, 15'd0);
    push_cmd(CMD_SCAN, 3'd0, 15'd0, 15'd0);
    push_cmd(CMD_TICK, 3'd0, 15'd0, 15'd0);
    push_cmd(CMD_SCAN, 3'd0, 15'd0, 15'd0);
    drain();
    no_idle = 1'b0;

    push_random(20);
    drain();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("run covered %0d loads, %0d ticks, %0d scans, %0d ignored words",
             n_loads, n_ticks, n_scans, n_ignored);
    $display("checked %0d release words, %0d mismatches", n_words, fails);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
